// File: hdl/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg: shared types and constants of the mesh route table
// Field widths, outcome codes and the request record that moves along the
// chain of table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mrt_pkg;

  localparam int ADDR_W      = 48;
  localparam int HOPS_W      = 8;
  localparam int ST_W        = 3;
  localparam int DEF_ENTRIES = 16;

  // Outcome codes reported with every result.
  localparam logic [ST_W-1:0] ST_LOOKUP   = 3'd0;
  localparam logic [ST_W-1:0] ST_ADDED    = 3'd1;
  localparam logic [ST_W-1:0] ST_IMPROVED = 3'd2;
  localparam logic [ST_W-1:0] ST_KEPT     = 3'd3;
  localparam logic [ST_W-1:0] ST_DROPPED  = 3'd4;

  // A request in flight, together with the partial result gathered so far.
  typedef struct packed {
    logic              action;   // 0 lookup, 1 update
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] via;
    logic [HOPS_W-1:0] offered;
    logic              done;     // some cell has already handled it
    logic              hit;
    logic [ADDR_W-1:0] next_hop;
    logic [HOPS_W-1:0] hops;
    logic [ST_W-1:0]   status;
  } req_t;

endpackage

`default_nettype wire

// File: hdl/mesh_route_table.sv
// ----------------------------------------------------------------------------
// mesh_route_table: exact-match routing table with minimum-hop updates
// Flow: an accepted request walks the chain of cells and then the output register;
// the block takes no new request until the chain is empty.
// Reset: rst clears the entry count and all valid flags; slot contents are
// left as they are and are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_route_table
  import mrt_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_addr [47:0], via_addr [95:48], offered_hops [103:96]
  input  wire  [103:0] s_axis_tdata,
  // action [0]
  input  wire  [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // next_hop [47:0], hops [55:48]
  output logic [55:0]  m_axis_tdata,
  // hit [0], status [3:1]
  output logic [3:0]   m_axis_tuser
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  // The table is a row of ENTRIES cells, one slot each, kept in insertion
  // order. A request enters cell 0 and moves one cell per cycle. The first
  // occupied cell whose key matches serves it; if none matches, the cell
  // whose index equals the entry count appends an update. Only one request
  // is in the chain at a time, so the count stays fixed during its walk.
  logic              in_accept;
  req_t              in_req;
  logic [CNT_W-1:0]  count;

  logic [ENTRIES-1:0] stage_valid;
  req_t               stage_req [ENTRIES];

  logic busy;
  logic move;
  req_t out_req;

  assign busy          = |stage_valid;
  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // A new request starts as a miss; its status is what a miss reports:
  // a lookup that finds nothing, or an update dropped because the table is full.
  always_comb begin
    in_req          = '0;
    in_req.action   = s_axis_tuser[0];
    in_req.dest     = s_axis_tdata[47:0];
    in_req.via      = s_axis_tdata[95:48];
    in_req.offered  = s_axis_tdata[103:96];
    in_req.status   = s_axis_tuser[0] ? ST_DROPPED : ST_LOOKUP;
  end

  // The last cell holds its finished request until the output register is
  // free; a new request can walk the chain while a result waits in that register.
  assign move = stage_valid[ENTRIES-1] && (!m_axis_tvalid || m_axis_tready);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic cell_in_valid;
    req_t cell_in_req;
    logic cell_take;

    if (i == 0) begin : g_first
      assign cell_in_valid = in_accept;
      assign cell_in_req   = in_req;
    end else begin : g_rest
      assign cell_in_valid = stage_valid[i-1];
      assign cell_in_req   = stage_req[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign cell_take = move;
    end else begin : g_mid
      assign cell_take = 1'b1;
    end

    mrt_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_in_valid),
      .in_req    (cell_in_req),
      .take      (cell_take),
      .count     (count),
      .out_valid (stage_valid[i]),
      .out_req   (stage_req[i])
    );
  end

  // The count grows when an appended request leaves the chain, before the
  // next request can enter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (move && (stage_req[ENTRIES-1].status == ST_ADDED)) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_req <= stage_req[ENTRIES-1];
    end
  end

  assign m_axis_tdata = {out_req.hops, out_req.next_hop};
  assign m_axis_tuser = {out_req.status, out_req.hit};

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table size");

  // Only one request walks the chain at a time.
  a_one_in_chain: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stage_valid))
    else $error("more than one request in the cell chain");

  // An update is dropped only when every slot is taken.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_req.status == ST_DROPPED) |-> count == CNT_W'(ENTRIES))
    else $error("update dropped while the table had room");

  // An appended entry was absent before, so it never reports a hit.
  a_added_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_req.status == ST_ADDED) |-> !out_req.hit)
    else $error("added entry reported as a hit");

endmodule

`default_nettype wire

// File: hdl/mrt_cell.sv
// ----------------------------------------------------------------------------
// mrt_cell: one slot of the route table
// Holds one key, next hop and hop count, serves the passing request and
// registers it for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_cell
  import mrt_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int IDX     = 0
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire req_t                       in_req,
  input  wire                             take,
  input  wire [$clog2(ENTRIES+1)-1:0]     count,
  output logic                            out_valid,
  output req_t                            out_req
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [ADDR_W-1:0] key;
  logic [ADDR_W-1:0] hop_addr;
  logic [HOPS_W-1:0] hop_count;

  logic occupied;
  logic match;
  logic append;
  logic improve;
  req_t req_next;

  assign occupied = CNT_W'(IDX) < count;
  assign match    = !in_req.done && occupied && (key == in_req.dest);
  assign append   = !in_req.done && in_req.action && (count == CNT_W'(IDX));
  assign improve  = match && in_req.action && (in_req.offered < hop_count);

  always_comb begin
    req_next = in_req;
    if (match) begin
      req_next.done     = 1'b1;
      req_next.hit      = 1'b1;
      req_next.next_hop = improve ? in_req.via : hop_addr;
      req_next.hops     = improve ? in_req.offered : hop_count;
      if (!in_req.action) begin
        req_next.status = ST_LOOKUP;
      end else if (improve) begin
        req_next.status = ST_IMPROVED;
      end else begin
        req_next.status = ST_KEPT;
      end
    end else if (append) begin
      req_next.done     = 1'b1;
      req_next.next_hop = in_req.via;
      req_next.hops     = in_req.offered;
      req_next.status   = ST_ADDED;
    end
  end

  // Slot contents: written by an append or an improving update.
  always_ff @(posedge clk) begin
    if (in_valid && append) begin
      key       <= in_req.dest;
      hop_addr  <= in_req.via;
      hop_count <= in_req.offered;
    end else if (in_valid && improve) begin
      hop_addr  <= in_req.via;
      hop_count <= in_req.offered;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid) begin
      out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_req <= req_next;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_mesh_route_table.sv
// ----------------------------------------------------------------------------
// tb_mesh_route_table: self-checking testbench of the mesh route table
// Drives lookup and update requests into the stream input, keeps its own
// copy of the routing table to predict each result, and compares every
// returned result field by field in order. Both stream sides idle at random,
// and the output side is held off for a long stretch to force the block to
// stall its input.
// ----------------------------------------------------------------------------
module tb_mesh_route_table;
  timeunit 1ns;
  timeprecision 1ps;

  import mrt_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int SLOTS        = DEF_ENTRIES;
  localparam int MAX_GAP      = 13;
  localparam int LIMIT_CYCLES = 500000;
  // Wait well past the walk of one request through the cell chain.
  localparam int SETTLE_CYCLES = 3 * DEF_ENTRIES + 8;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
  localparam logic [HOPS_W-1:0] HOPS_MAX  = {HOPS_W{1'b1}};

  // One result as the block reports it.
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] next_hop;
    logic [HOPS_W-1:0] hops;
    logic [ST_W-1:0]   status;
  } route_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // dest_addr [47:0], via_addr [95:48], offered_hops [103:96]
  logic [103:0] s_axis_tdata = '0;
  // action [0]
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // next_hop [47:0], hops [55:48]
  logic [55:0]  m_axis_tdata;
  // hit [0], status [3:1]
  logic [3:0]   m_axis_tuser;

  // Predicted routing table: keys, next hops and hop counts in insertion order.
  logic [ADDR_W-1:0] route_key  [SLOTS];
  logic [ADDR_W-1:0] route_via  [SLOTS];
  logic [HOPS_W-1:0] route_hops [SLOTS];
  int                route_count = 0;

  route_result_t pending_routes[$];

  int  errors       = 0;
  int  cycles       = 0;
  int  rx_wait      = 0;
  int  rx_hold_left = 0;
  bit  gaps_on      = 1'b1;

  mesh_route_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle cycles before the next request or result; zero in burst stretches.
  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ADDR_W-1:0];
  endfunction

  // Applies one request to the predicted table and returns the result that
  // the block must report for it. Keys are unique, so the first match is the
  // only one, and only slots below the entry count are ever examined.
  function automatic route_result_t route_apply(input logic action,
                                                input logic [ADDR_W-1:0] dest,
                                                input logic [ADDR_W-1:0] via,
                                                input logic [HOPS_W-1:0] offered);
    route_result_t res;
    int slot;
    res  = '0;
    slot = -1;
    for (int i = 0; i < route_count; i++) begin
      if (slot < 0 && route_key[i] == dest) slot = i;
    end
    if (action == ACT_LOOKUP) begin
      res.status = ST_LOOKUP;
      if (slot >= 0) begin
        res.hit      = 1'b1;
        res.next_hop = route_via[slot];
        res.hops     = route_hops[slot];
      end
    end else if (slot >= 0) begin
      // A present entry is replaced only by a strictly shorter path.
      res.hit = 1'b1;
      if (offered < route_hops[slot]) begin
        route_via[slot]  = via;
        route_hops[slot] = offered;
        res.status       = ST_IMPROVED;
      end else begin
        res.status = ST_KEPT;
      end
      res.next_hop = route_via[slot];
      res.hops     = route_hops[slot];
    end else if (route_count < SLOTS) begin
      route_key[route_count]  = dest;
      route_via[route_count]  = via;
      route_hops[route_count] = offered;
      route_count++;
      res.next_hop = via;
      res.hops     = offered;
      res.status   = ST_ADDED;
    end else begin
      // The table is full: the update is dropped and hit, next hop and hops read zero.
      res.status = ST_DROPPED;
    end
    return res;
  endfunction

  // Offers one request after a random idle stretch and records its predicted
  // result once the block accepts it. The task is entered and left just after
  // a falling edge, with tvalid left high so back-to-back requests see no gap.
  task automatic send_route_req(input logic action, input logic [ADDR_W-1:0] dest,
                                input logic [ADDR_W-1:0] via,
                                input logic [HOPS_W-1:0] offered);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {offered, via, dest};
    s_axis_tuser  = action;
    do @(posedge clk); while (!s_axis_tready);
    pending_routes.push_back(route_apply(action, dest, via, offered));
    @(negedge clk);
  endtask

  // Builds a random request. Most requests target a known destination so that
  // lookups hit and updates exercise the improve and keep paths; the rest are
  // near misses (one address bit flipped) and entirely random destinations.
  task automatic send_random_req();
    logic              action;
    logic [ADDR_W-1:0] dest;
    logic [HOPS_W-1:0] offered;
    int                pick;
    int                slot;
    int                mode;
    action = 1'($urandom_range(0, 1));
    pick   = $urandom_range(0, 99);
    mode   = $urandom_range(0, 9);
    slot   = -1;
    if (route_count > 0 && pick < 70) begin
      slot = $urandom_range(0, route_count - 1);
      dest = route_key[slot];
    end else if (route_count > 0 && pick < 85) begin
      dest = route_key[$urandom_range(0, route_count - 1)] ^
             (48'd1 << $urandom_range(0, ADDR_W - 1));
    end else begin
      dest = rand_addr();
    end
    // Bias the offered hop count around the stored one so that improvements
    // keep happening even after the stored counts have shrunk.
    if (slot >= 0 && mode < 4 && route_hops[slot] > 0) begin
      offered = HOPS_W'($urandom_range(0, route_hops[slot] - 1));
    end else if (slot >= 0 && mode < 6) begin
      offered = route_hops[slot];
    end else begin
      offered = HOPS_W'($urandom_range(0, HOPS_MAX));
    end
    send_route_req(action, dest, rand_addr(), offered);
  endtask

  // Stops offering requests until every predicted result has been returned.
  task automatic wait_for_results();
    s_axis_tvalid = 1'b0;
    while (pending_routes.size() != 0) @(negedge clk);
  endtask

  // Lookups on the empty table must miss, whatever the ignored fields hold.
  task automatic test_empty_lookups();
    send_route_req(ACT_LOOKUP, '0, '0, '0);
    send_route_req(ACT_LOOKUP, ADDR_ONES, ADDR_ONES, HOPS_MAX);
  endtask

  // Adds two entries at the address extremes, then offers equal, shorter and
  // longer paths to them. An equal hop count keeps the stored route.
  task automatic test_updates_on_present();
    send_route_req(ACT_UPDATE, ADDR_ONES, '0, HOPS_MAX);
    send_route_req(ACT_UPDATE, '0, ADDR_ONES, '0);
    send_route_req(ACT_LOOKUP, ADDR_ONES, rand_addr(), '0);
    send_route_req(ACT_LOOKUP, '0, '0, HOPS_MAX);
    send_route_req(ACT_UPDATE, ADDR_ONES, ADDR_ONES, HOPS_MAX);
    send_route_req(ACT_UPDATE, ADDR_ONES, 48'hA5A5_5A5A_A5A5, HOPS_MAX - 1);
    send_route_req(ACT_UPDATE, ADDR_ONES, 48'h1234_5678_9ABC, HOPS_MAX);
    send_route_req(ACT_UPDATE, '0, 48'h5A5A_A5A5_5A5A, '0);
  endtask

  // Fills the remaining slots, then checks that new destinations are dropped
  // and missed on the full table.
  task automatic test_fill_and_drop();
    while (route_count < SLOTS) begin
      send_route_req(ACT_UPDATE, rand_addr(), rand_addr(),
                     HOPS_W'($urandom_range(0, HOPS_MAX)));
    end
    send_route_req(ACT_UPDATE, rand_addr(), rand_addr(), '0);
    send_route_req(ACT_UPDATE, route_key[SLOTS - 1] ^ 48'h8000_0000_0000, ADDR_ONES, '0);
    send_route_req(ACT_LOOKUP, rand_addr(), '0, '0);
  endtask

  // Holds the output side off for a long stretch while requests keep coming
  // without gaps, so the cell chain fills and the input must stall.
  task automatic test_back_pressure();
    gaps_on = 1'b0;
    @(posedge clk);
    rx_hold_left = 400;
    @(negedge clk);
    repeat (40) send_random_req();
    gaps_on = 1'b1;
  endtask

  // Lets the block run completely dry between bursts of requests.
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (15) send_random_req();
      wait_for_results();
    end
  endtask

  // Random traffic in phases, most with idling on both sides and some as
  // uninterrupted bursts.
  task automatic test_random_traffic(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (50) send_random_req();
      sent += 50;
    end
    gaps_on = 1'b1;
  endtask

  // Output side: a long hold-off when one is requested, otherwise a random
  // stall drawn after each accepted result.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready = 1'b0;
    end else if (rx_hold_left > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else if (rx_wait > 0) begin
      m_axis_tready = 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    route_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rx_wait = draw_gap();
      if (pending_routes.size() == 0) begin
        $error("result with no request outstanding: next_hop %h hops %0d",
               m_axis_tdata[47:0], m_axis_tdata[55:48]);
        errors++;
      end else begin
        want = pending_routes.pop_front();
        if (m_axis_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata[47:0] !== want.next_hop) begin
          $error("next_hop: expected %h, actual %h", want.next_hop, m_axis_tdata[47:0]);
          errors++;
        end
        if (m_axis_tdata[55:48] !== want.hops) begin
          $error("hops: expected %0d, actual %0d", want.hops, m_axis_tdata[55:48]);
          errors++;
        end
        if (m_axis_tuser[3:1] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser[3:1]);
          errors++;
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_lookups();
    test_updates_on_present();
    test_fill_and_drop();
    test_back_pressure();
    test_drain_pause();
    test_random_traffic(1450);

    // Every result must be back, and nothing more may follow.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
